// ===== rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, constants and codes shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int NUM_BLOCKS   = 65536;
  localparam int BLOCK_BYTES  = 64;
  localparam int HEADER_BYTES = 32;

  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int LEN_W       = BLK_W + 1;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int ADDR_W      = 32;
  localparam int REQ_W       = 23;
  localparam int NEED_W      = REQ_W + 1 - BLOCK_SHIFT + 1;
  localparam int STEP_W      = LEN_W + 1;
  localparam int SPLIT_W     = NEED_W + 1;
  localparam int FREE_W      = 23;
  localparam int STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic             is_free;
    logic [LEN_W-1:0] length;
  } head_t;

  localparam int HEAD_W = $bits(head_t);

  // request context handed to the walk unit
  typedef struct packed {
    logic              action;
    logic [NEED_W-1:0] need;
    logic [ADDR_W-1:0] release_address;
    logic [ADDR_W-1:0] region_base;
  } walk_req_t;

  // outcome of evaluating one segment head
  typedef struct packed {
    logic               len_zero;
    logic               hit;
    logic               at_end;
    logic [STEP_W-1:0]  next_blk;
    logic [ADDR_W-1:0]  payload;
    logic [LEN_W-1:0]   rest;
    logic               split_ok;
    logic [SPLIT_W-1:0] split_idx;
  } walk_res_t;

endpackage

// ===== rtl/first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit allocator over a chain of fixed-size blocks with split on alloc.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser is the action (0 allocate,
// 1 free), s_tdata carries request_bytes and release_address. Each request
// gives exactly one result on the m_ stream: m_tuser is the status,
// m_tdata carries granted_address and free_bytes.
// The request walks the segment chain from block 0, one segment head per
// cycle through the head memory's registered read port and the shared walk
// unit. A request that finds its segment goes from S_EVAL to S_COMMIT,
// then S_SPLIT for an allocate that splits, then S_DONE; a request that
// finds nothing goes from S_EVAL to S_DONE once the chain ends. S_DONE
// loads the output register when it is empty or m_tready drains it.
// One request is in flight at a time; s_tready is high only while the
// sequencer is idle and out of reset, which it reaches as the result is
// loaded into the output register.
// A finished result sits in the output register; a new request is taken
// while it waits, but that request's result holds until m_tready drains it.
// Reset sets region_base to 0x1000000 and frees all blocks as one segment.
// Block 0's reset head comes from a flag, so no clearing pass is run and
// the block is ready in the cycle after reset.
// region_base is written over the APB port; the user must write it only while no request is active (not enforced).
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // request_bytes[22:0], release_address[54:23], zero
  input  logic        s_tuser,   // action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // granted_address[31:0], free_bytes[54:32], zero
  output logic [1:0]  m_tuser    // status
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [BLK_W-1:0]    blk;
  logic                action_q;
  logic [NEED_W-1:0]   need_q;
  logic [ADDR_W-1:0]   rel_q;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    rest_q;
  logic                was_free_q;
  logic                split_ok_q;
  logic [BLK_W-1:0]    split_q;
  logic [ADDR_W-1:0]   granted_q;
  logic [STATUS_W-1:0] status_q;
  logic [LEN_W-1:0]    free_count;
  logic [ADDR_W-1:0]   region_base;
  logic                head0_init;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_granted;
  logic [STATUS_W-1:0] out_status;
  logic [FREE_W-1:0]   out_free;

  logic              in_fire;
  logic              cfg_wr;
  logic [REQ_W-1:0]  in_req;
  logic [NEED_W-1:0] in_need;
  logic              mem_we;
  logic [BLK_W-1:0]  mem_waddr;
  head_t             mem_wdata;
  logic [BLK_W-1:0]  mem_raddr;
  head_t             mem_rdata;
  head_t             head;
  walk_req_t         wreq;
  walk_res_t         wres;
  logic              done_load;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == 1'b0) ? region_base : 32'd0;

  assign s_tready = (state == S_IDLE) && !rst;
  assign in_fire  = s_tvalid && s_tready;
  assign in_req   = s_tdata[REQ_W-1:0];
  assign in_need  = NEED_W'((REQ_W + 1)'(in_req) + (REQ_W + 1)'(HEADER_BYTES) >> BLOCK_SHIFT)
                    + NEED_W'(1);

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_free, out_granted};
  assign m_tuser  = out_status;

  assign done_load = (state == S_DONE) && (!out_valid || m_tready);

  // block 0 reads as one free segment over the whole region until written
  assign head = (head0_init && (blk == '0))
                ? head_t'{is_free: 1'b1, length: LEN_W'(NUM_BLOCKS)} : mem_rdata;

  assign wreq.action          = action_q;
  assign wreq.need            = need_q;
  assign wreq.release_address = rel_q;
  assign wreq.region_base     = region_base;

  ffba_walk_unit u_walk (
    .req  (wreq),
    .blk  (blk),
    .head (head),
    .res  (wres)
  );

  ffba_head_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    mem_raddr = '0;
    if (state == S_EVAL) begin
      mem_raddr = wres.next_blk[BLK_W-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = blk;
    mem_wdata = head_t'{is_free: 1'b0, length: LEN_W'(need_q)};
    if (state == S_COMMIT) begin
      if (action_q == ACT_ALLOC) begin
        mem_we = 1'b1;
      end else begin
        mem_we    = !was_free_q;
        mem_wdata = head_t'{is_free: 1'b1, length: len_q};
      end
    end else if (state == S_SPLIT) begin
      mem_we    = 1'b1;
      mem_waddr = split_q;
      mem_wdata = head_t'{is_free: 1'b1, length: rest_q};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (wres.len_zero) begin
          state_next = S_DONE;
        end else if (wres.hit) begin
          state_next = S_COMMIT;
        end else if (wres.at_end) begin
          state_next = S_DONE;
        end
      end
      S_COMMIT: begin
        if ((action_q == ACT_ALLOC) && split_ok_q) state_next = S_SPLIT;
        else state_next = S_DONE;
      end
      S_SPLIT: state_next = S_DONE;
      S_DONE: begin
        if (done_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      region_base <= 32'h0100_0000;
      free_count  <= LEN_W'(NUM_BLOCKS);
      head0_init  <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr && (paddr[2] == 1'b0)) begin
        region_base <= pwdata;
      end
      if (mem_we && (mem_waddr == '0)) begin
        head0_init <= 1'b0;
      end
      if (state == S_COMMIT) begin
        if (action_q == ACT_ALLOC) begin
          free_count <= free_count - LEN_W'(need_q);
        end else if (!was_free_q) begin
          free_count <= free_count + len_q;
        end
      end
      if (done_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_q  <= s_tuser;
      need_q    <= in_need;
      rel_q     <= s_tdata[REQ_W +: ADDR_W];
      blk       <= '0;
      granted_q <= '0;
      status_q  <= STATUS_OK;
    end
    if (state == S_EVAL) begin
      if (!wres.len_zero && wres.hit) begin
        len_q      <= head.length;
        rest_q     <= wres.rest;
        was_free_q <= head.is_free;
        split_ok_q <= wres.split_ok;
        split_q    <= wres.split_idx[BLK_W-1:0];
        if (action_q == ACT_ALLOC) granted_q <= wres.payload;
      end else if (wres.len_zero || wres.at_end) begin
        status_q <= (action_q == ACT_ALLOC) ? STATUS_NO_SPACE : STATUS_NOT_FOUND;
      end else begin
        blk <= wres.next_blk[BLK_W-1:0];
      end
    end
    if (done_load) begin
      out_granted <= granted_q;
      out_status  <= status_q;
      out_free    <= {free_count[FREE_W-BLOCK_SHIFT-1:0], BLOCK_SHIFT'(0)};
    end
  end

endmodule

// ===== rtl/ffba_head_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_head_mem
// Segment head store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_head_mem
  import ffba_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [BLK_W-1:0] waddr,
  input  head_t            wdata,
  input  logic [BLK_W-1:0] raddr,
  output head_t            rdata
);

  head_t mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ffba_walk_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_walk_unit
// Shared step unit: checks one segment head against the request and forms
// the next head index, payload address and split point.
// ----------------------------------------------------------------------------
module ffba_walk_unit
  import ffba_pkg::*;
(
  input  walk_req_t        req,
  input  logic [BLK_W-1:0] blk,
  input  head_t            head,
  output walk_res_t        res
);

  logic [ADDR_W-1:0] offset;

  always_comb begin
    // blk * block size + header, low bits of the block offset are zero
    offset = ADDR_W'({blk, BLOCK_SHIFT'(0)}) + ADDR_W'(HEADER_BYTES);
    res.payload   = req.region_base + offset;
    res.len_zero  = (head.length == '0);
    res.next_blk  = STEP_W'(blk) + STEP_W'(head.length);
    res.at_end    = (res.next_blk >= STEP_W'(NUM_BLOCKS));
    if (req.action == ACT_ALLOC) begin
      res.hit = head.is_free && (NEED_W'(head.length) >= req.need);
    end else begin
      res.hit = (res.payload == req.release_address);
    end
    res.rest      = head.length - LEN_W'(req.need);
    res.split_idx = SPLIT_W'(blk) + SPLIT_W'(req.need);
    res.split_ok  = (res.rest != '0) && (res.split_idx < SPLIT_W'(NUM_BLOCKS));
  end

endmodule

// ===== rtl/ffba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit block allocator, bound to the core.
// ----------------------------------------------------------------------------
module ffba_checker
  import ffba_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a failed request never grants an address
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tdata[31:0] == 32'd0))
    else $error("failed request returned an address");

  // free bytes are whole blocks
  a_free_whole_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[32 +: BLOCK_SHIFT] == '0))
    else $error("free_bytes not a multiple of the block size");

  // an accepted request keeps the input closed while it is evaluated and completed
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("request finished too early");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

// ===== verif/ffba_alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_alloc_checker
// Watches the request, result and apb channels of the first-fit allocator.
// It keeps its own copy of the segment chain, free-block count and region
// base. It predicts the result of every accepted request and compares each
// result transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ffba_alloc_checker
  import ffba_pkg::*;
#(
  parameter logic [2:0] REGION_BASE_ADDR = 3'd0
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // request_bytes[22:0], release_address[54:23], zero
  input  logic        s_tuser,   // action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // granted_address[31:0], free_bytes[54:32], zero
  input  logic [1:0]  m_tuser,   // status
  output int          mismatches,
  output int          outstanding,
  output int          grants,
  output int          refusals,
  output int          misses
);

  localparam logic [ADDR_W-1:0] BASE_AT_RESET = 32'h0100_0000;
  localparam int                REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_bytes;
  } alloc_reply_t;

  head_t             chain [NUM_BLOCKS];
  logic [LEN_W-1:0]  free_blocks;
  logic [ADDR_W-1:0] base_addr;
  alloc_reply_t      predicted_replies [$];

  // payload address wraps at 32 bits
  function automatic logic [ADDR_W-1:0] payload_at(int unsigned blk);
    return base_addr + ADDR_W'(blk * BLOCK_BYTES) + ADDR_W'(HEADER_BYTES);
  endfunction

  function automatic alloc_reply_t serve_request(logic act, logic [REQ_W-1:0] req,
                                                 logic [ADDR_W-1:0] rel);
    alloc_reply_t reply;
    int unsigned  blk;
    int unsigned  need;
    int unsigned  rest;
    bit           hit;
    reply        = '0;
    reply.status = STATUS_OK;
    blk          = 0;
    hit          = 1'b0;
    if (act == ACT_ALLOC) begin
      need = (32'(req) + HEADER_BYTES) / BLOCK_BYTES + 1;
      while (!hit && blk < NUM_BLOCKS && chain[blk].length != 0) begin
        if (chain[blk].is_free && chain[blk].length >= need) hit = 1'b1;
        else blk += chain[blk].length;
      end
      if (hit) begin
        rest = chain[blk].length - need;
        // exact fit leaves no empty segment behind
        if (rest != 0 && blk + need < NUM_BLOCKS)
          chain[blk + need] = '{is_free: 1'b1, length: LEN_W'(rest)};
        chain[blk]    = '{is_free: 1'b0, length: LEN_W'(need)};
        free_blocks  -= LEN_W'(need);
        reply.granted = payload_at(blk);
        grants++;
      end else begin
        reply.status = STATUS_NO_SPACE;
        refusals++;
      end
    end else begin
      while (!hit && blk < NUM_BLOCKS && chain[blk].length != 0) begin
        if (payload_at(blk) == rel) hit = 1'b1;
        else blk += chain[blk].length;
      end
      if (!hit) begin
        reply.status = STATUS_NOT_FOUND;
        misses++;
      end else if (!chain[blk].is_free) begin
        chain[blk].is_free = 1'b1;
        free_blocks       += chain[blk].length;
      end
    end
    reply.free_bytes = FREE_W'(free_blocks * BLOCK_BYTES);
    return reply;
  endfunction

  always @(posedge clk) begin
    alloc_reply_t want;
    alloc_reply_t got;
    if (rst) begin
      foreach (chain[i]) chain[i] = '0;
      chain[0]    = '{is_free: 1'b1, length: LEN_W'(NUM_BLOCKS)};
      free_blocks = LEN_W'(NUM_BLOCKS);
      base_addr   = BASE_AT_RESET;
      predicted_replies.delete();
      mismatches  = 0;
      grants      = 0;
      refusals    = 0;
      misses      = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REGION_BASE_ADDR)
        base_addr = pwdata;
      if (m_tvalid && m_tready) begin
        got = '{granted: m_tdata[31:0], status: m_tuser, free_bytes: m_tdata[54:32]};
        if (predicted_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with no request pending: addr %h status %0d free %0d",
                     $time, got.granted, got.status, got.free_bytes);
        end else begin
          want = predicted_replies.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: expected addr %h status %0d free %0d, got addr %h status %0d free %0d",
                       $time, want.granted, want.status, want.free_bytes,
                       got.granted, got.status, got.free_bytes);
          end
        end
      end
      if (s_tvalid && s_tready)
        predicted_replies.push_back(serve_request(s_tuser, s_tdata[22:0], s_tdata[54:23]));
    end
    outstanding = predicted_replies.size();
  end

endmodule

// ===== verif/tb_first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_core
// Drives allocate and free requests into the allocator, with bursts of idle
// cycles on both streams, and moves the region base between phases. A
// directed opening covers whole-region fits, exhaustion, exact fits, double
// frees, unknown addresses and a base that wraps payload addresses to zero;
// random phases follow. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator_core;
  import ffba_pkg::*;

  localparam logic [2:0]        REGION_BASE_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] BASE_AT_RESET    = 32'h0100_0000;
  localparam logic [ADDR_W-1:0] WRAP_BASE        = 32'hFFFF_FFE0;
  localparam int                MAX_REQUEST      = 4194304;
  localparam int                FULL_FIT_MAX     = 4194271;
  localparam int                FULL_FIT_MIN     = 4194208;
  localparam int                RANDOM_ITEMS     = 800;
  localparam int                PHASES           = 5;
  localparam int                CALM_ITEMS       = 100;
  localparam int                STALL_LIMIT      = 5000;
  localparam int                DRAIN_CYCLES     = 20;
  localparam int                POOL_DEPTH       = 256;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  int                mismatches;
  int                outstanding;
  int                grants;
  int                refusals;
  int                misses;
  int                requests_sent;
  int                config_writes;
  int                quiet_cycles;
  bit                calm;
  logic [ADDR_W-1:0] cur_base;
  logic [ADDR_W-1:0] live_grants [$];

  first_fit_block_allocator_core dut (.*);

  ffba_alloc_checker #(.REGION_BASE_ADDR(REGION_BASE_ADDR)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // granted addresses feed later free requests
  always @(posedge clk) begin
    if (m_tvalid && m_tready && m_tuser == STATUS_OK && m_tdata[31:0] != '0) begin
      live_grants.push_back(m_tdata[31:0]);
      if (live_grants.size() > POOL_DEPTH) void'(live_grants.pop_front());
    end
  end

  // result side back-pressure
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        m_tready = 1'b1;
        repeat ($urandom_range(0, 24)) @(negedge clk);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: %0d cycles without a transaction", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the accept
  task automatic issue(input logic act, input logic [REQ_W-1:0] req,
                       input logic [ADDR_W-1:0] rel);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = {1'b0, rel, req};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic alloc(input int unsigned req);
    issue(ACT_ALLOC, REQ_W'(req), $urandom);
  endtask

  task automatic give_back(input logic [ADDR_W-1:0] addr);
    issue(ACT_FREE, REQ_W'($urandom_range(0, MAX_REQUEST)), addr);
  endtask

  // only while the block is idle: every result in hand
  task automatic set_base(input logic [ADDR_W-1:0] value);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = REGION_BASE_ADDR;
    pwdata  = value;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    cur_base = value;
    config_writes++;
  endtask

  function automatic int unsigned random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return $urandom_range(0, 255);
    if (pick < 88) return $urandom_range(256, 8191);
    if (pick < 97) return $urandom_range(8192, 131071);
    if (pick < 99) return $urandom_range(0, MAX_REQUEST);
    return MAX_REQUEST;
  endfunction

  task automatic random_request();
    int          pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      alloc(random_size());
    end else if (pick < 88 && live_grants.size() != 0) begin
      idx = $urandom_range(0, live_grants.size() - 1);
      give_back(live_grants[idx]);
      live_grants.delete(idx);
    end else if (pick < 94) begin
      // lands on a head or in the middle of a segment
      give_back(cur_base + HEADER_BYTES + BLOCK_BYTES * $urandom_range(0, 4095));
    end else begin
      give_back($urandom);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] old_base;
    logic [ADDR_W-1:0] phase_bases [PHASES];
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = ACT_ALLOC;
    calm          = 1'b0;
    cur_base      = BASE_AT_RESET;
    requests_sent = 0;
    config_writes = 0;
    phase_bases   = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, BASE_AT_RESET, WRAP_BASE};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // whole region as one exact fit, exhausted, freed twice, refilled
    alloc(FULL_FIT_MAX);
    alloc(0);
    give_back(cur_base + HEADER_BYTES);
    give_back(cur_base + HEADER_BYTES);
    alloc(MAX_REQUEST);
    alloc(FULL_FIT_MIN);
    give_back(cur_base + HEADER_BYTES);
    // carve small segments, then free some and one address inside a segment
    alloc(0);
    alloc(31);
    alloc(32);
    give_back(cur_base + HEADER_BYTES + BLOCK_BYTES);
    give_back(cur_base + HEADER_BYTES + 2 * BLOCK_BYTES);
    give_back(cur_base + HEADER_BYTES + 3 * BLOCK_BYTES);
    give_back('0);
    give_back('1);
    // exact fits into the freed holes, then a split further on
    alloc(0);
    alloc(33);
    alloc(95);
    // base moved under live segments, block 0 payload wraps to zero
    old_base = cur_base;
    set_base(WRAP_BASE);
    give_back('0);
    alloc(0);
    give_back(old_base + HEADER_BYTES + BLOCK_BYTES);

    for (int p = 0; p < PHASES; p++) begin
      set_base(phase_bases[p]);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        calm = (p == PHASES - 1) && (i >= RANDOM_ITEMS / PHASES - CALM_ITEMS);
        random_request();
      end
    end
    s_tvalid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d requests over %0d base settings", requests_sent, config_writes + 1);
    $display("  %0d grants, %0d out of space, %0d unknown addresses", grants, refusals, misses);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ffba_pkg.sv
rtl/ffba_head_mem.sv
rtl/ffba_walk_unit.sv
rtl/first_fit_block_allocator_core.sv
rtl/ffba_checker.sv
verif/ffba_alloc_checker.sv
verif/tb_first_fit_block_allocator_core.sv
